// File: rtl/kht_pkg.sv
// Shared types, widths and codes for the key/handle registration table.
// No dependencies; used by kht_ctrl, kht_dp and the top module.
`default_nettype none

package kht_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W       = 32;
    localparam int HND_W       = 16;
    localparam int ENTRY_W     = KEY_W + HND_W;

    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 5;
    localparam int COUNT_W     = 6;

    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 24;
    localparam int M_PAD_W     = M_TDATA_W - STATUS_W - SLOT_W - 2 * COUNT_W;

    // request kinds (s_tuser)
    localparam logic FUNC_REG   = 1'b0;
    localparam logic FUNC_UNREG = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNREG_DONE = 2'd3;

    typedef struct packed {
        logic load;     // capture the input beat, restart the scan
        logic scan;     // walk the used entries
        logic commit;   // apply the outcome and issue the result beat
    } kht_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } kht_sts_t;

endpackage

`default_nettype wire

// File: rtl/kht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module kht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/kht_ctrl.sv
// Controller FSM: accept a request, run the entry scan, then commit the result.
// Depends on kht_pkg.
`default_nettype none

module kht_ctrl (
    input  wire logic              clk,
    input  wire logic              rstn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire kht_pkg::kht_sts_t sts,
    output kht_pkg::kht_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register can take a new beat
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/kht_dp.sv
// Datapath: entry RAM, valid bits, used length, scan pipeline and result register.
// Depends on kht_pkg and kht_ram.
`default_nettype none

module kht_dp (
    input  wire logic                            clk,
    input  wire logic                            rstn,
    input  wire kht_pkg::kht_cmd_t               cmd,
    output kht_pkg::kht_sts_t                    sts,
    input  wire logic                            in_func,
    input  wire logic [kht_pkg::KEY_W-1:0]       in_key,
    input  wire logic [kht_pkg::HND_W-1:0]       in_handle,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [kht_pkg::M_TDATA_W-1:0]   out_data
);

    localparam int IDX_W = kht_pkg::IDX_W;
    localparam int LEN_W = kht_pkg::LEN_W;

    // captured request
    logic                        func_reg;
    logic [kht_pkg::KEY_W-1:0]   key_reg;
    logic [kht_pkg::HND_W-1:0]   hnd_reg;

    logic [LEN_W-1:0]            len_reg, len_next;
    logic [kht_pkg::TABLE_DEPTH-1:0] vld_reg;

    // scan pipeline: address issue, then data in the cycle after
    logic [LEN_W-1:0]            rd_idx_reg;
    logic                        pend_reg;
    logic [IDX_W-1:0]            pidx_reg;
    logic                        pval_reg;

    // scan results
    logic                        found_reg;
    logic                        zfound_reg;
    logic [IDX_W-1:0]            zidx_reg;
    logic [LEN_W-1:0]            rem_reg;
    logic [LEN_W-1:0]            newlen_reg;

    // result beat
    logic                        ovld_reg;
    logic [kht_pkg::STATUS_W-1:0] ost_reg, ost_next;
    logic [kht_pkg::SLOT_W-1:0]  oslot_reg, oslot_next;
    logic [kht_pkg::COUNT_W-1:0] orem_reg, orem_next;

    logic                        issue;
    logic [kht_pkg::ENTRY_W-1:0] rdata;
    logic [kht_pkg::KEY_W-1:0]   key_rd;
    logic [kht_pkg::HND_W-1:0]   hdl_rd;
    logic                        key_hit, clr_hit, keep_nz;
    logic                        add_en;
    logic [IDX_W-1:0]            add_slot;
    logic                        we;
    logic [IDX_W-1:0]            waddr;
    logic [kht_pkg::ENTRY_W-1:0] wdata;

    assign issue  = cmd.scan && (rd_idx_reg < len_reg);
    assign key_rd = rdata[kht_pkg::KEY_W-1:0];
    // an entry never written reads as an empty handle
    assign hdl_rd = pval_reg ? rdata[kht_pkg::ENTRY_W-1:kht_pkg::KEY_W] : '0;

    assign key_hit = pend_reg && (func_reg == kht_pkg::FUNC_REG) && (key_rd == key_reg);
    assign clr_hit = pend_reg && (func_reg == kht_pkg::FUNC_UNREG) && (hnd_reg != '0)
                     && (hdl_rd == hnd_reg);
    assign keep_nz = (hdl_rd != '0) && !clr_hit;

    assign sts.scan_done = (rd_idx_reg == len_reg) && !pend_reg;
    assign sts.out_free  = !ovld_reg || out_ready;

    always_comb begin
        add_en     = 1'b0;
        add_slot   = '0;
        len_next   = len_reg;
        ost_next   = kht_pkg::ST_FULL;
        oslot_next = '0;
        orem_next  = '0;
        if (func_reg == kht_pkg::FUNC_UNREG) begin
            ost_next  = kht_pkg::ST_UNREG_DONE;
            orem_next = kht_pkg::COUNT_W'(rem_reg);
            len_next  = newlen_reg;
        end else if (found_reg) begin
            ost_next = kht_pkg::ST_PRESENT;
        end else if (len_reg < LEN_W'(kht_pkg::TABLE_DEPTH)) begin
            add_en   = 1'b1;
            add_slot = len_reg[IDX_W-1:0];
            len_next = len_reg + LEN_W'(1);
        end else if (zfound_reg) begin
            // full table: reuse the lowest empty entry
            add_en   = 1'b1;
            add_slot = zidx_reg;
        end
        if (add_en) begin
            ost_next   = kht_pkg::ST_ADDED;
            oslot_next = kht_pkg::SLOT_W'(add_slot);
        end
    end

    // clears during the scan write back the key just read
    assign we    = clr_hit || (cmd.commit && add_en);
    assign waddr = cmd.commit ? add_slot : pidx_reg;
    assign wdata = cmd.commit ? {hnd_reg, key_reg} : {{kht_pkg::HND_W{1'b0}}, key_rd};

    kht_ram #(
        .WIDTH (kht_pkg::ENTRY_W),
        .DEPTH (kht_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            key_reg  <= in_key;
            hnd_reg  <= in_handle;
        end
        pidx_reg <= rd_idx_reg[IDX_W-1:0];
        pval_reg <= vld_reg[rd_idx_reg[IDX_W-1:0]];
        if (cmd.commit) begin
            ost_reg   <= ost_next;
            oslot_reg <= oslot_next;
            orem_reg  <= orem_next;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            len_reg    <= '0;
            vld_reg    <= '0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            zfound_reg <= 1'b0;
            zidx_reg   <= '0;
            rem_reg    <= '0;
            newlen_reg <= '0;
            ovld_reg   <= 1'b0;
        end else begin
            pend_reg <= issue;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + LEN_W'(1);
            end
            if (key_hit) begin
                found_reg <= 1'b1;
            end
            if (clr_hit) begin
                rem_reg <= rem_reg + LEN_W'(1);
            end
            if (pend_reg && (hdl_rd == '0) && !zfound_reg) begin
                zfound_reg <= 1'b1;
                zidx_reg   <= pidx_reg;
            end
            // ascending scan: the last surviving entry sets the trimmed length
            if (pend_reg && keep_nz) begin
                newlen_reg <= LEN_W'(pidx_reg) + LEN_W'(1);
            end
            if (cmd.load) begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
                zfound_reg <= 1'b0;
                rem_reg    <= '0;
                newlen_reg <= '0;
            end
            if (cmd.commit) begin
                len_reg  <= len_next;
                ovld_reg <= 1'b1;
                if (add_en) begin
                    vld_reg[add_slot] <= 1'b1;
                end
            end else if (out_ready) begin
                ovld_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ovld_reg;
    assign out_data  = {{kht_pkg::M_PAD_W{1'b0}}, kht_pkg::COUNT_W'(len_reg), orem_reg,
                        oslot_reg, ost_reg};

endmodule

`default_nettype wire

// File: rtl/key_handle_registration_table.sv
// Key/handle registration table: 32 entries of 32-bit key and 16-bit handle with a used
// length; register appends a new key or reuses an empty entry when full, unregister clears
// a handle everywhere and trims trailing empty entries. One request is handled at a time.
// After the input beat is taken, the scan walks the used entries through the single
// registered read port of the entry RAM, one entry per cycle; then the last read drains
// and the result commits. The next input beat can be taken after the commit. The commit
// also waits while the previous result beat is still held by m_tready. A new request is
// taken while that beat waits.
// No clearing pass after reset: entry handles carry valid bits cleared by reset.
// Depends on kht_pkg, kht_ctrl, kht_dp and kht_ram.
`default_nettype none

module key_handle_registration_table (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [kht_pkg::S_TDATA_W-1:0]   s_tdata,   // key[31:0], handle[47:32]
    input  wire logic                            s_tuser,   // func
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [kht_pkg::M_TDATA_W-1:0]   m_tdata    // status[1:0], slot[6:2],
                                                            // removed_count[12:7],
                                                            // used_length[18:13], zero pad
);

    kht_pkg::kht_cmd_t cmd;
    kht_pkg::kht_sts_t sts;

    kht_ctrl u_ctrl (
        .clk      (aclk),
        .rstn     (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kht_dp u_dp (
        .clk       (aclk),
        .rstn      (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_func   (s_tuser),
        .in_key    (s_tdata[kht_pkg::KEY_W-1:0]),
        .in_handle (s_tdata[kht_pkg::ENTRY_W-1:kht_pkg::KEY_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // one request in flight: no second beat right after an accepted one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a request is in progress");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:13] <= 6'(kht_pkg::TABLE_DEPTH)))
        else $error("used length beyond table depth");

    a_add_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == kht_pkg::ST_ADDED)) |->
            ((m_tdata[18:13] != 6'd0) && (m_tdata[12:7] == 6'd0)))
        else $error("add result with empty table or nonzero removed count");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != kht_pkg::ST_ADDED)) |-> (m_tdata[6:2] == 5'd0))
        else $error("slot set on a result that wrote no entry");

endmodule

`default_nettype wire

// File: verif/key_handle_registration_table_test.sv
// Self-checking testbench for key_handle_registration_table: stream driver and monitor
// with random gaps and stalls, checked against an in-bench model of the entry table.
// Depends on kht_pkg and the key_handle_registration_table RTL.

module key_handle_registration_table_test;

    import kht_pkg::*;

    localparam int ITEM_COUNT  = 1850;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;
    localparam int RECENT_KEYS = 16;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
        logic [HND_W-1:0] handle;
        logic             wait_drain;   // hold this beat until all results are back
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  removed;
        logic [COUNT_W-1:0]  length;
    } outcome_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // key[31:0], handle[47:32]
    logic                 s_tuser  = 1'b0; // func
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // status, slot, removed_count, used_length, pad

    // model of the entry table
    logic [KEY_W-1:0] tbl_keys    [TABLE_DEPTH];
    logic [HND_W-1:0] tbl_handles [TABLE_DEPTH];
    int               tbl_len = 0;

    request_t pending [$];
    outcome_t expected [$];
    request_t cur;

    logic [KEY_W-1:0] recent_keys [RECENT_KEYS];
    int recent_wr = 0;

    bit sending    = 1'b0;
    bit beat_taken = 1'b0;
    int send_gap   = 0;
    int send_calm  = 0;
    int ready_gap  = 0;
    int ready_calm = 0;
    int cycles     = 0;
    int errors     = 0;

    int n_added = 0, n_present = 0, n_dropped = 0, n_unreg = 0, n_cleared = 0;
    int n_at_full = 0, n_drains = 0;

    always #4 aclk = ~aclk;

    key_handle_registration_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic outcome_t apply_request(input request_t rq);
        outcome_t o;
        bit       hit;
        int       slot;
        int       removed;
        o = '0;
        if (rq.func == FUNC_REG) begin
            hit = 1'b0;
            for (int i = 0; i < tbl_len; i++)
                if (tbl_keys[i] == rq.key) hit = 1'b1;
            if (hit) begin
                o.status = ST_PRESENT;
            end else begin
                slot = -1;
                if (tbl_len >= TABLE_DEPTH) begin
                    // full: reuse the lowest empty entry
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                        if (tbl_handles[i] == '0) slot = i;
                end else begin
                    slot = tbl_len;
                    tbl_len++;
                end
                if (slot < 0) begin
                    o.status = ST_FULL;
                end else begin
                    tbl_keys[slot]    = rq.key;
                    tbl_handles[slot] = rq.handle;
                    o.status = ST_ADDED;
                    o.slot   = SLOT_W'(slot);
                end
            end
        end else begin
            removed = 0;
            if (rq.handle != '0) begin
                for (int i = 0; i < tbl_len; i++) begin
                    if (tbl_handles[i] == rq.handle) begin
                        tbl_handles[i] = '0;
                        removed++;
                    end
                end
            end
            while (tbl_len != 0 && tbl_handles[tbl_len-1] == '0)
                tbl_len--;
            o.status  = ST_UNREG_DONE;
            o.removed = COUNT_W'(removed);
        end
        o.length = COUNT_W'(tbl_len);
        return o;
    endfunction

    // idle cycles before the next beat, with occasional stretches of none
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic request_t make_request(input int reg_pct);
        request_t rq;
        int       roll;
        rq = '0;
        rq.func = ($urandom_range(0, 99) < reg_pct) ? FUNC_REG : FUNC_UNREG;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            rq.key = $urandom;
        else if (roll < 90)
            rq.key = recent_keys[$urandom_range(0, RECENT_KEYS - 1)];
        else if (roll < 95)
            rq.key = KEY_W'($urandom_range(0, 3));
        else
            rq.key = ~KEY_W'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 70)
            rq.handle = HND_W'($urandom_range(1, 6));   // small pool so handles repeat
        else if (roll < 80)
            rq.handle = '0;
        else if (roll < 92)
            rq.handle = HND_W'($urandom);
        else
            rq.handle = '1;
        if (rq.func == FUNC_REG) begin
            recent_keys[recent_wr] = rq.key;
            recent_wr = (recent_wr + 1) % RECENT_KEYS;
        end
        return rq;
    endfunction

    task automatic queue_request(input logic func, input logic [KEY_W-1:0] key,
                                 input logic [HND_W-1:0] handle, input bit drain);
        request_t rq;
        rq.func       = func;
        rq.key        = key;
        rq.handle     = handle;
        rq.wait_drain = drain;
        pending.push_back(rq);
    endtask

    task automatic note_failure(input string why, input outcome_t want, input outcome_t got);
        errors++;
        if (errors <= 10)
            $display("%0d: %s: expected st=%0d slot=%0d rm=%0d len=%0d, got st=%0d slot=%0d rm=%0d len=%0d",
                     cycles, why, want.status, want.slot, want.removed, want.length,
                     got.status, got.slot, got.removed, got.length);
    endtask

    // driver: one beat in flight at a time, gap drawn per beat
    always @(negedge aclk) begin
        if (aresetn) begin
            if (sending && beat_taken)
                sending = 1'b0;
            beat_taken = 1'b0;
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending.size() != 0 &&
                             !(pending[0].wait_drain && expected.size() != 0)) begin
                    cur = pending.pop_front();
                    if (cur.wait_drain) n_drains++;
                    sending  = 1'b1;
                    send_gap = draw_wait(send_calm);
                end
            end
            s_tvalid <= sending;
            s_tdata  <= {cur.handle, cur.key};
            s_tuser  <= cur.func;
        end
    end

    always @(negedge aclk) begin
        if (ready_gap > 0) begin
            ready_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: predict on accepted input beats, check accepted result beats
    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                beat_taken = 1'b1;
                want = apply_request(cur);
                expected.push_back(want);
                case (want.status)
                    ST_ADDED:   n_added++;
                    ST_PRESENT: n_present++;
                    ST_FULL:    n_dropped++;
                    default: begin
                        n_unreg++;
                        n_cleared += want.removed;
                    end
                endcase
                if (want.length == COUNT_W'(TABLE_DEPTH)) n_at_full++;
            end
            if (m_tvalid && m_tready) begin
                got.status  = m_tdata[1:0];
                got.slot    = m_tdata[6:2];
                got.removed = m_tdata[12:7];
                got.length  = m_tdata[18:13];
                if (expected.size() == 0) begin
                    note_failure("result beat with nothing pending", '0, got);
                end else begin
                    want = expected.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.removed !== want.removed || got.length !== want.length)
                        note_failure("result mismatch", want, got);
                end
                ready_gap = draw_wait(ready_calm);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        request_t rq;
        int       phase_left;
        int       reg_pct;

        for (int i = 0; i < RECENT_KEYS; i++) recent_keys[i] = '0;
        cur = '0;

        // directed: empty table, extremes, cleared keys, zero handles, trimming
        queue_request(FUNC_UNREG, 32'h1234_5678, 16'h0000, 1'b0);
        queue_request(FUNC_REG,   32'h0000_0000, 16'hFFFF, 1'b0);
        queue_request(FUNC_REG,   32'hFFFF_FFFF, 16'h0001, 1'b0);
        queue_request(FUNC_REG,   32'h0000_0000, 16'h0002, 1'b0);
        queue_request(FUNC_REG,   32'h0000_0005, 16'h0000, 1'b0);
        queue_request(FUNC_UNREG, 32'hA5A5_5A5A, 16'hFFFF, 1'b0);
        queue_request(FUNC_REG,   32'h0000_0000, 16'h0003, 1'b1);
        queue_request(FUNC_REG,   32'h0000_0005, 16'h0004, 1'b0);
        queue_request(FUNC_REG,   32'h0000_000A, 16'h0007, 1'b0);
        queue_request(FUNC_REG,   32'h0000_000B, 16'h0007, 1'b0);
        queue_request(FUNC_REG,   32'h0000_000C, 16'h0007, 1'b0);
        queue_request(FUNC_UNREG, 32'h0000_0000, 16'h0000, 1'b0);
        queue_request(FUNC_UNREG, 32'hFFFF_FFFF, 16'h0007, 1'b0);
        queue_request(FUNC_UNREG, 32'h0000_0000, 16'h0001, 1'b0);
        // key 11 sits above the used length now, so it is not compared
        queue_request(FUNC_REG,   32'h0000_000B, 16'hFFFF, 1'b0);
        queue_request(FUNC_UNREG, 32'h0000_0000, 16'h0004, 1'b1);

        // random: phases that lean toward filling or draining the table
        reg_pct    = 95;
        phase_left = 60;
        while (pending.size() < ITEM_COUNT) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 3))
                    0:       reg_pct = 90;
                    1:       reg_pct = 65;
                    2:       reg_pct = 50;
                    default: reg_pct = 25;
                endcase
            end
            rq = make_request(reg_pct);
            rq.wait_drain = ($urandom_range(0, 199) == 0);
            pending.push_back(rq);
            phase_left--;
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || sending || expected.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d added, %0d already present, %0d dropped when full",
                 n_added + n_present + n_dropped + n_unreg, n_added, n_present, n_dropped);
        $display("%0d unregisters cleared %0d entries; %0d results at full length, %0d drains",
                 n_unreg, n_cleared, n_at_full, n_drains);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
